// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the hash set top level.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SHP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SHP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/shp_pkg.sv =====
// Shared types and constants of the string hash set.
// Depends on nothing; used by the controller, datapath and top level.
package shp_pkg;

   localparam int CHAR_W     = 7;
   localparam int CFG_W      = 11;
   localparam int STATUS_W   = 2;
   localparam int HASH_SHIFT = 8;

   // Lower case codes start here and move down by the case offset.
   localparam logic [CHAR_W-1:0] FOLD_LIMIT = 7'd97;
   localparam logic [CHAR_W-1:0] FOLD_DELTA = 7'd32;
   // Hash bias: 128 minus the code of 'A'.
   localparam logic [HASH_SHIFT-1:0] HASH_BIAS = 8'd63;
   localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 11'd1024;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_LONG = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       clr_write;
      logic       accept;
      logic       div_step;
      logic       probe_next;
      logic       insert;
      logic       idx_clear;
      logic       idx_inc;
      logic       chars_write;
      logic       load_out;
      logic       out_present;
      status_type out_status;
      logic       key_clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic div_done;
      logic last_q;
      logic overlong;
      logic slot_valid;
      logic len_match;
      logic char_eq;
      logic idx_last;
      logic q_last;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/core/shp_if.sv =====
// Valid/ready stream interfaces for the request and response channels.
// Depends on nothing.
interface shp_req_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface shp_rsp_if;
   logic       valid;
   logic       ready;
   logic       already_present;
   logic [1:0] status;

   modport source (output valid, output already_present, output status, input ready);
   modport sink (input valid, input already_present, input status, output ready);
endinterface

// ===== rtl/core/shp_dpath.sv =====
// Datapath of the hash set: key buffer, hash divider, slot tables and result register.
// Depends on shp_pkg; driven by shp_ctrl through cmd_type and stat_type.
module shp_dpath #(
   parameter int TABLE_DEPTH = 1024,
   parameter int MAX_KEY_LEN = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  shp_pkg::cmd_type              cmd,
   output shp_pkg::stat_type             stat,
   input  logic [shp_pkg::CHAR_W-1:0]    req_char_code,
   input  logic                          req_last_char,
   input  logic                          csr_we,
   input  logic [shp_pkg::CFG_W-1:0]     csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_already_present,
   output logic [shp_pkg::STATUS_W-1:0]  rsp_status
);
   import shp_pkg::*;

   localparam int HW  = $clog2(TABLE_DEPTH);
   localparam int SW  = $clog2(TABLE_DEPTH + 1);
   localparam int TW  = HW + 1;
   localparam int LW  = $clog2(MAX_KEY_LEN + 1);
   localparam int IW  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
   localparam int DW  = HW + HASH_SHIFT;
   localparam int CNW = $clog2(DW + 1);
   localparam int CMW = (SW > CFG_W) ? SW : CFG_W;

   // Registers.
   logic [CFG_W-1:0]  table_size_ff;
   logic [SW-1:0]     size_ff;
   logic [LW-1:0]     key_len_ff;
   logic [HW-1:0]     hash_ff;
   logic              overlong_ff;
   logic              last_ff;
   logic [HW-1:0]     rem_ff;
   logic [DW-1:0]     dvd_ff;
   logic [CNW-1:0]    cnt_ff;
   logic [HW-1:0]     slot_ff;
   logic [SW-1:0]     probe_cnt_ff;
   logic [LW-1:0]     idx_ff;
   logic [HW-1:0]     clr_idx_ff;
   logic              out_valid_ff;
   logic              out_present_ff;
   status_type        out_status_ff;
   logic              valid_q_ff;
   logic [LW-1:0]     len_q_ff;
   logic [CHAR_W-1:0] kchar_q_ff;
   logic [CHAR_W-1:0] schar_q_ff;

   // Memories.
   logic              valid_mem [TABLE_DEPTH];
   logic [LW-1:0]     len_mem   [TABLE_DEPTH];
   logic [CHAR_W-1:0] char_mem  [TABLE_DEPTH << IW];
   logic [CHAR_W-1:0] kbuf_mem  [MAX_KEY_LEN];

   logic [CMW-1:0]        cfg_ext;
   logic [SW-1:0]         size_now;
   logic [CHAR_W-1:0]     c_fold;
   logic [HASH_SHIFT-1:0] hash_add;
   logic [TW-1:0]         div_t;
   logic [TW-1:0]         div_sub;
   logic [HW-1:0]         rem_in;
   logic [HW-1:0]         slot_in;
   logic [HW+IW-1:0]      char_addr;

   // Effective table size: zero acts as one, large values clamp to the depth.
   always_comb begin
      cfg_ext = CMW'(table_size_ff);
      if (cfg_ext == '0) begin
         size_now = SW'(1);
      end else if (cfg_ext > CMW'(TABLE_DEPTH)) begin
         size_now = SW'(TABLE_DEPTH);
      end else begin
         size_now = SW'(cfg_ext);
      end
   end

   // Case fold and hash addend of the incoming character.
   always_comb begin
      c_fold   = (req_char_code >= FOLD_LIMIT) ? (req_char_code - FOLD_DELTA) : req_char_code;
      hash_add = {1'b0, c_fold} + HASH_BIAS;
   end

   // One restoring remainder step; the remainder always stays below the size.
   always_comb begin
      div_t   = {rem_ff, dvd_ff[DW-1]};
      div_sub = (div_t >= TW'(size_ff)) ? (div_t - TW'(size_ff)) : div_t;
      rem_in  = div_sub[HW-1:0];
   end

   // Linear probe successor with wraparound at the size.
   always_comb begin
      slot_in = ((TW'(slot_ff) + TW'(1)) == TW'(size_ff)) ? '0 : (slot_ff + HW'(1));
   end

   assign char_addr = {slot_ff, idx_ff[IW-1:0]};

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RESET;
      end else if (csr_we) begin
         table_size_ff <= csr_wdata;
      end
   end

   // Key state: length, overlong flag and running hash.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff  <= '0;
         overlong_ff <= 1'b0;
         hash_ff     <= '0;
      end else if (cmd.key_clear) begin
         key_len_ff  <= '0;
         overlong_ff <= 1'b0;
         hash_ff     <= '0;
      end else begin
         if (cmd.accept) begin
            if (key_len_ff < LW'(MAX_KEY_LEN)) begin
               key_len_ff <= key_len_ff + LW'(1);
            end else begin
               overlong_ff <= 1'b1;
            end
         end
         if (cmd.div_step && (cnt_ff == CNW'(1))) begin
            hash_ff <= rem_in;
         end
      end
   end

   // Key buffer write on each accepted character that still fits.
   always_ff @(posedge clock) begin
      if (cmd.accept && (key_len_ff < LW'(MAX_KEY_LEN))) begin
         kbuf_mem[key_len_ff[IW-1:0]] <= c_fold;
      end
      kchar_q_ff <= kbuf_mem[idx_ff[IW-1:0]];
   end

   // Divider registers; the final step also seeds the probe.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         last_ff <= req_last_char;
         size_ff <= size_now;
         rem_ff  <= '0;
         dvd_ff  <= {hash_ff, hash_add};
         cnt_ff  <= CNW'(DW);
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[DW-2:0], 1'b0};
         cnt_ff <= cnt_ff - CNW'(1);
      end
      if (cmd.div_step && (cnt_ff == CNW'(1))) begin
         slot_ff      <= rem_in;
         probe_cnt_ff <= '0;
      end else if (cmd.probe_next) begin
         slot_ff      <= slot_in;
         probe_cnt_ff <= probe_cnt_ff + SW'(1);
      end
      if (cmd.idx_clear) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + LW'(1);
      end
   end

   // Clearing pass index.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clr_write) begin
         clr_idx_ff <= clr_idx_ff + HW'(1);
      end
   end

   // Slot valid and length tables.
   always_ff @(posedge clock) begin
      if (cmd.clr_write) begin
         valid_mem[clr_idx_ff] <= 1'b0;
      end else if (cmd.insert) begin
         valid_mem[slot_ff] <= 1'b1;
      end
      if (cmd.insert) begin
         len_mem[slot_ff] <= key_len_ff;
      end
      valid_q_ff <= valid_mem[slot_ff];
      len_q_ff   <= len_mem[slot_ff];
   end

   // Stored key characters.
   always_ff @(posedge clock) begin
      if (cmd.chars_write) begin
         char_mem[char_addr] <= kchar_q_ff;
      end
      schar_q_ff <= char_mem[char_addr];
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         out_present_ff <= cmd.out_present;
         out_status_ff  <= cmd.out_status;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_already_present = out_present_ff;
   assign rsp_status          = out_status_ff;

   // Status to the controller.
   always_comb begin
      stat.clr_last   = (clr_idx_ff == HW'(TABLE_DEPTH - 1));
      stat.div_done   = (cnt_ff == CNW'(1));
      stat.last_q     = last_ff;
      stat.overlong   = overlong_ff;
      stat.slot_valid = valid_q_ff;
      stat.len_match  = (len_q_ff == key_len_ff);
      stat.char_eq    = (kchar_q_ff == schar_q_ff);
      stat.idx_last   = (({1'b0, idx_ff} + (LW+1)'(1)) == {1'b0, key_len_ff});
      stat.q_last     = (probe_cnt_ff == (size_ff - SW'(1)));
      stat.out_free   = !out_valid_ff || rsp_ready;
   end

endmodule

// ===== rtl/core/shp_ctrl.sv =====
// Controller state machine of the hash set: clearing, hashing, probing, copy and compare.
// Depends on shp_pkg; commands shp_dpath through cmd_type and reads stat_type.
module shp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  shp_pkg::stat_type  stat,
   output shp_pkg::cmd_type   cmd
);
   import shp_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_PROBE_RD,
      ST_PROBE_CHK,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_CMP_RD,
      ST_CMP_CHK,
      ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic       res_present_ff, res_present_in;
   status_type res_status_ff, res_status_in;

   // State and pending result code.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         res_present_ff <= 1'b0;
         res_status_ff  <= STATUS_OK;
      end else begin
         state_ff       <= state_in;
         res_present_ff <= res_present_in;
         res_status_ff  <= res_status_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in        = state_ff;
      res_present_in  = res_present_ff;
      res_status_in   = res_status_ff;
      cmd             = '0;
      cmd.out_present = res_present_ff;
      cmd.out_status  = res_status_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               priority if (!stat.last_q) begin
                  state_in = ST_IDLE;
               end else if (stat.overlong) begin
                  res_present_in = 1'b0;
                  res_status_in  = STATUS_LONG;
                  state_in       = ST_FINISH;
               end else begin
                  state_in = ST_PROBE_RD;
               end
            end
         end
         ST_PROBE_RD: begin
            state_in = ST_PROBE_CHK;
         end
         ST_PROBE_CHK: begin
            priority if (!stat.slot_valid) begin
               cmd.insert    = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in      = ST_COPY_RD;
            end else if (stat.len_match) begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_CMP_RD;
            end else if (stat.q_last) begin
               res_present_in = 1'b0;
               res_status_in  = STATUS_FULL;
               state_in       = ST_FINISH;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = ST_PROBE_RD;
            end
         end
         ST_COPY_RD: begin
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            cmd.chars_write = 1'b1;
            cmd.idx_inc     = 1'b1;
            if (stat.idx_last) begin
               res_present_in = 1'b0;
               res_status_in  = STATUS_OK;
               state_in       = ST_FINISH;
            end else begin
               state_in = ST_COPY_RD;
            end
         end
         ST_CMP_RD: begin
            state_in = ST_CMP_CHK;
         end
         ST_CMP_CHK: begin
            priority if (!stat.char_eq && stat.q_last) begin
               res_present_in = 1'b0;
               res_status_in  = STATUS_FULL;
               state_in       = ST_FINISH;
            end else if (!stat.char_eq) begin
               cmd.probe_next = 1'b1;
               state_in       = ST_PROBE_RD;
            end else if (stat.idx_last) begin
               res_present_in = 1'b1;
               res_status_in  = STATUS_OK;
               state_in       = ST_FINISH;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_CMP_RD;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.load_out  = 1'b1;
               cmd.key_clear = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// ===== rtl/core/string_hash_set_linear_probe.sv =====
// Each character is reduced by the one-bit-per-cycle remainder unit before the next
// is taken. A last character of a key that fits then reads and checks each probed slot,
// reads and compares each stored character, copies each character on insert, and posts the result.
// After reset a clearing pass empties the slot table; requests wait until it ends
// while configuration writes are still taken.
module string_hash_set_linear_probe #(
   parameter int TABLE_DEPTH = 1024,
   parameter int MAX_KEY_LEN = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   shp_req_if.sink                    req_bus,
   shp_rsp_if.source                  rsp_bus,
   input  logic                       csr_we,
   input  logic [shp_pkg::CFG_W-1:0]  csr_wdata
);
   import shp_pkg::*;
   `include "assert_macros.svh"

   cmd_type  cmd;
   stat_type stat;

   // Controller.
   shp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath.
   shp_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_KEY_LEN (MAX_KEY_LEN)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_char_code       (req_bus.char_code),
      .req_last_char       (req_bus.last_char),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_already_present (rsp_bus.already_present),
      .rsp_status          (rsp_bus.status)
   );

   // A transaction is never taken while the slot table is being cleared.
   `SHP_ASSERT_IMP(a_no_req_in_clear, clock, reset, cmd.clr_write, !req_bus.ready)
   // A result is loaded only when the output register is free or being drained.
   `SHP_ASSERT_IMP(a_load_when_free, clock, reset, cmd.load_out, stat.out_free)
   // The engine goes busy right after it takes a character.
   `SHP_ASSERT_NXT(a_busy_after_accept, clock, reset, req_bus.valid && req_bus.ready,
                   !req_bus.ready)

endmodule
